// ===== rtl/weighted_window_fir_filter_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the weighted window FIR filter
// Shared property forms, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_WINDOW_FIR_FILTER_ASSERT_SVH
`define WEIGHTED_WINDOW_FIR_FILTER_ASSERT_SVH

// Same-cycle implication
`define WWF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication
`define WWF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/wwf_pkg.sv =====
// ---------------------------------------------------------------------------
// wwf_pkg
// Shared types and constants of the weighted window FIR filter.
// ---------------------------------------------------------------------------
package wwf_pkg;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 6;
  localparam int COEF_W   = 16;
  localparam int OUT_W    = 38;
  // Signed sample times unsigned weight (weight gets a zero sign bit)
  localparam int PROD_W   = SAMPLE_W + COEF_W + 1;

  // Default window length
  localparam int TAPS_DEFAULT = 64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_OUT
  } wwf_state_t;

  // Per-cell history control
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== rtl/weighted_window_fir_filter.sv =====
// ---------------------------------------------------------------------------
// weighted_window_fir_filter
// Direct-form FIR over the TAPS newest samples with loadable Q0.16 weights.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command, sample, coef_index and
//   coef_value. A filter word shifts the sample into the history and yields
//   one output word on filtered (out_valid/out_ready): the sum of weight[i]
//   times the i-th newest sample, Q.16, saturated to 38 bits. A load word
//   writes one weight (indexes at or above TAPS are dropped), a clear word
//   zeroes the history; neither yields an output. Command 3 is ignored.
//   A filter word runs through the multiply-accumulate chain (one tap per
//   cycle) and then into the output register; in_ready rises again in the
//   same cycle as out_valid, so no new word is accepted until the last
//   filter result has reached the output register. Load and clear words
//   leave the block ready for the next word.
//   Reset zeroes history and weights and leaves the block ready. While the
//   receiver stalls, the output register holds its word and input goes on;
//   a second filter result waits in the chain and then blocks the input.
// ---------------------------------------------------------------------------
`include "weighted_window_fir_filter_assert.svh"

module weighted_window_fir_filter
  import wwf_pkg::*;
#(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic        [CMD_W-1:0]    command,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [IDX_W-1:0]    coef_index,
  input  logic        [COEF_W-1:0]   coef_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    filtered
);

  localparam int ACC_W = PROD_W - 1 + $clog2(TAPS);
  localparam int SAT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W;
  localparam int CNT_W = $clog2(TAPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);
  localparam logic signed [SAT_W-1:0] SAT_MAX = (SAT_W'(1) <<< (OUT_W - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);

  wwf_state_t       state, state_next;
  logic [CNT_W-1:0] run_cnt;
  logic             in_fire, out_fire;
  logic             filt_fire, load_fire;
  logic             load_out;
  logic             run_more;
  logic             out_full;
  cell_ctl_t        ctl;

  logic signed [SAMPLE_W-1:0] sample_chain [TAPS+1];
  logic signed [ACC_W-1:0]    acc_chain    [TAPS+1];
  logic signed [SAT_W-1:0]    sum_ext;
  logic signed [OUT_W-1:0]    sat_sum;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign filt_fire = in_fire && (command == CMD_FILTER);
  assign load_fire = in_fire && (command == CMD_LOAD);
  assign ctl.shift = filt_fire;
  assign ctl.clear = in_fire && (command == CMD_CLEAR);
  assign load_out  = (state == S_OUT) && (!out_full || out_ready);
  assign run_more  = (state == S_RUN) && (run_cnt != CNT_LAST);
  assign out_valid = out_full;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (filt_fire) state_next = S_RUN;
      S_RUN:   if (run_cnt == CNT_LAST) state_next = S_OUT;
      S_OUT:   if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_RUN:   ;
      S_OUT:   ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Cycle count while the sum runs down the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (state == S_RUN) begin
      run_cnt <= run_cnt + CNT_W'(1);
    end else begin
      run_cnt <= '0;
    end
  end

  // Tap chain: samples move toward older taps, partial sums the same way
  assign sample_chain[0] = sample;
  assign acc_chain[0]    = '0;

  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    logic wr_en;
    assign wr_en = load_fire && (32'(coef_index) == i);

    wwf_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .sample_in  (sample_chain[i]),
      .sample_out (sample_chain[i+1]),
      .wr_en      (wr_en),
      .wr_value   (coef_value),
      .acc_in     (acc_chain[i]),
      .acc_out    (acc_chain[i+1])
    );
  end

  // Saturate the chain result to the output width
  assign sum_ext = SAT_W'(acc_chain[TAPS]);

  always_comb begin
    if (sum_ext > SAT_MAX) begin
      sat_sum = OUT_W'(SAT_MAX);
    end else if (sum_ext < SAT_MIN) begin
      sat_sum = OUT_W'(SAT_MIN);
    end else begin
      sat_sum = OUT_W'(sum_ext);
    end
  end

  // Output register: takes the chain result, holds it until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      filtered <= '0;
    end else if (load_out) begin
      out_full <= 1'b1;
      filtered <= sat_sum;
    end else if (out_fire) begin
      out_full <= 1'b0;
    end
  end

  `WWF_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(filtered))
  `WWF_ASSERT_NEXT(a_filter_starts_run, filt_fire, state == S_RUN)
  `WWF_ASSERT_NEXT(a_run_counts, run_more, run_cnt == $past(run_cnt) + CNT_W'(1))
  `WWF_ASSERT_NEXT(a_result_loads, load_out, out_valid && (state == S_IDLE))

endmodule

// ===== rtl/wwf_cell.sv =====
// ---------------------------------------------------------------------------
// wwf_cell
// One tap: holds a history sample and a weight, adds its product to the
// partial sum arriving from the previous tap and registers it onward.
// ---------------------------------------------------------------------------
module wwf_cell
  import wwf_pkg::*;
#(
  parameter int ACC_W = 38
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cell_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic signed [SAMPLE_W-1:0] sample_out,
  input  logic                       wr_en,
  input  logic        [COEF_W-1:0]   wr_value,
  input  logic signed [ACC_W-1:0]    acc_in,
  output logic signed [ACC_W-1:0]    acc_out
);

  logic signed [SAMPLE_W-1:0] hist;
  logic        [COEF_W-1:0]   weight;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  // History slot: shift from neighbor, or clear
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hist <= '0;
    end else if (ctl.shift) begin
      hist <= sample_in;
    end
  end

  // Tap weight
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (wr_en) begin
      weight <= wr_value;
    end
  end

  // Multiply-accumulate, one stage of the sum chain
  assign prod = hist * $signed({1'b0, weight});

  always_ff @(posedge clk) begin
    acc <= acc_in + ACC_W'(prod);
  end

  assign sample_out = hist;
  assign acc_out    = acc;

endmodule
